FILE: rtl/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

	localparam int SLOTS  = 4;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		CMD_ATTACH     = 2'd0,
		CMD_DETACH     = 2'd1,
		CMD_DETACH_CUR = 2'd2,
		CMD_FIND       = 2'd3
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		cmd_e_t      command;
		logic [15:0] terminal_id;
	} request_t;

	typedef struct packed {
		logic       ok;
		logic [2:0] session_id;
		logic       current_valid;
		logic [2:0] current_id;
		logic [2:0] active_count;
	} result_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_last;
	} dp_status_t;

endpackage

FILE: rtl/session_slot_table.sv
`timescale 1ns / 1ps

// Session slot table: attach, detach, detach-current and find on a small
// table of slots keyed by a 16-bit terminal id (zero is the null terminal).
// Request channel: request is taken at a rising edge with start high and
// busy low; busy stays high while the beat is worked on.
// Result channel: done is high for exactly one cycle with result valid;
// the receiver cannot hold it off, so nothing ever waits on the output.
// Timing: after the accepting edge the table is scanned one slot a cycle
// in the scan state, then the finish state applies the update and registers
// the result. done rises in the cycle that busy falls, so a new request
// can be taken only once the previous one is through; the scan through the
// slots takes most of the time of each request.
// Reset (arst_n low) frees every slot and clears the current mark; the
// stored terminal ids are not cleared, as a free slot is never matched.

module session_slot_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sst_pkg::request_t request,
	output logic              busy,
	output logic              done,
	output sst_pkg::result_t  result
);

	sst_pkg::ctrl_cmd_t  cmd;
	sst_pkg::dp_status_t status;

	sst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	sst_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.status  (status),
		.done    (done),
		.result  (result)
	);

endmodule

FILE: rtl/sst_ctrl.sv
`timescale 1ns / 1ps

module sst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  sst_pkg::dp_status_t status,
	output sst_pkg::ctrl_cmd_t  cmd,
	output logic                busy
);

	sst_pkg::state_t state_q;
	sst_pkg::state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sst_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			sst_pkg::ST_IDLE: begin
				if (start) begin
					state_n = sst_pkg::ST_SCAN;
				end
			end
			sst_pkg::ST_SCAN: begin
				if (status.scan_last) begin
					state_n = sst_pkg::ST_FINISH;
				end
			end
			sst_pkg::ST_FINISH: begin
				state_n = sst_pkg::ST_IDLE;
			end
			default: begin
				state_n = sst_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			sst_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			sst_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			sst_pkg::ST_FINISH: begin
				cmd.commit = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

FILE: rtl/sst_dp.sv
`timescale 1ns / 1ps

module sst_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  sst_pkg::ctrl_cmd_t  cmd,
	input  sst_pkg::request_t   request,
	output sst_pkg::dp_status_t status,
	output logic                done,
	output sst_pkg::result_t    result
);

	sst_pkg::cmd_e_t             op_q;
	logic [15:0]                 term_q;
	logic [sst_pkg::SLOT_W-1:0]  idx_q;
	logic                        hit_found_q;
	logic [sst_pkg::SLOT_W-1:0]  hit_idx_q;
	logic                        free_found_q;
	logic [sst_pkg::SLOT_W-1:0]  free_idx_q;
	logic [sst_pkg::SLOTS-1:0]   used_q;
	logic [15:0]                 term_mem_q [sst_pkg::SLOTS];
	logic [15:0]                 term_rd_q;
	logic                        cur_valid_q;
	logic [sst_pkg::SLOT_W-1:0]  cur_slot_q;
	logic                        done_q;
	sst_pkg::result_t            result_q;

	logic                        null_term;
	logic                        match;
	logic [sst_pkg::SLOTS-1:0]   used_n;
	logic                        cur_valid_n;
	logic [sst_pkg::SLOT_W-1:0]  cur_slot_n;
	logic                        wr_en;
	logic [sst_pkg::SLOT_W-1:0]  wr_idx;
	logic                        ok_n;
	logic [sst_pkg::SLOT_W-1:0]  sid_idx;
	logic [sst_pkg::CNT_W-1:0]   count_n;
	logic                        cv_out;
	sst_pkg::result_t            result_n;

	assign status.scan_last = (idx_q == sst_pkg::SLOT_W'(sst_pkg::SLOTS - 1));
	assign null_term        = (term_q == 16'd0);
	assign match            = used_q[idx_q] && (term_rd_q == term_q);

	// scan one slot a cycle, keep the lowest hit and the lowest free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.load) begin
			idx_q        <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.scan) begin
			idx_q <= idx_q + sst_pkg::SLOT_W'(1);
			if (match && !hit_found_q) begin
				hit_found_q <= 1'b1;
			end
			if (!used_q[idx_q] && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= request.command;
			term_q    <= request.terminal_id;
			term_rd_q <= term_mem_q[0];
		end
		if (cmd.scan) begin
			term_rd_q <= term_mem_q[idx_q + sst_pkg::SLOT_W'(1)];
			if (match && !hit_found_q) begin
				hit_idx_q <= idx_q;
			end
			if (!used_q[idx_q] && !free_found_q) begin
				free_idx_q <= idx_q;
			end
		end
	end

	always_comb begin
		used_n      = used_q;
		cur_valid_n = cur_valid_q;
		cur_slot_n  = cur_slot_q;
		wr_en       = 1'b0;
		wr_idx      = free_idx_q;
		ok_n        = 1'b0;
		sid_idx     = hit_idx_q;
		case (op_q)
			sst_pkg::CMD_ATTACH: begin
				if (!null_term) begin
					if (hit_found_q) begin
						cur_valid_n = 1'b1;
						cur_slot_n  = hit_idx_q;
						ok_n        = 1'b1;
					end else if (free_found_q) begin
						used_n[free_idx_q] = 1'b1;
						wr_en       = 1'b1;
						cur_valid_n = 1'b1;
						cur_slot_n  = free_idx_q;
						ok_n        = 1'b1;
						sid_idx     = free_idx_q;
					end
				end
			end
			sst_pkg::CMD_DETACH: begin
				if (!null_term && hit_found_q) begin
					used_n[hit_idx_q] = 1'b0;
					if (cur_valid_q && (cur_slot_q == hit_idx_q)) begin
						cur_valid_n = 1'b0;
					end
				end
			end
			sst_pkg::CMD_DETACH_CUR: begin
				if (cur_valid_q) begin
					used_n[cur_slot_q] = 1'b0;
					cur_valid_n = 1'b0;
				end
			end
			default: begin
				if (!null_term && hit_found_q) begin
					ok_n = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		count_n = '0;
		for (int i = 0; i < sst_pkg::SLOTS; i++) begin
			count_n = count_n + sst_pkg::CNT_W'(used_n[i]);
		end
	end

	assign cv_out = cur_valid_n && used_n[cur_slot_n];

	always_comb begin
		result_n.ok            = ok_n;
		result_n.session_id    = ok_n ? (3'(sid_idx) + 3'd1) : 3'd0;
		result_n.current_valid = cv_out;
		result_n.current_id    = cv_out ? (3'(cur_slot_n) + 3'd1) : 3'd0;
		result_n.active_count  = 3'(count_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			cur_valid_q <= 1'b0;
			cur_slot_q  <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.commit) begin
				used_q      <= used_n;
				cur_valid_q <= cur_valid_n;
				cur_slot_q  <= cur_slot_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_q <= result_n;
			if (wr_en) begin
				term_mem_q[wr_idx] <= term_q;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: tb/sst_result_checker.sv
`timescale 1ns / 1ps

module sst_result_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  sst_pkg::request_t request,
	input  logic              done,
	input  sst_pkg::result_t  result,
	output int                fails,
	output int                pending,
	output int                checked
);
	import sst_pkg::*;

	logic              slot_used [SLOTS];
	logic [15:0]       slot_term [SLOTS];
	logic              cur_valid;
	logic [SLOT_W-1:0] cur_slot;
	result_t           expected_q [$];
	result_t           want;

	function automatic result_t predict_step(request_t r);
		result_t res;
		int      hit;
		int      free_slot;
		int      used_n;
		bit      has_term;
		res = '0;
		hit = -1;
		free_slot = -1;
		used_n = 0;
		has_term = (r.terminal_id != 16'd0);
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (slot_used[i] && slot_term[i] == r.terminal_id)
				hit = i;
			if (!slot_used[i])
				free_slot = i;
		end
		case (r.command)
			CMD_ATTACH: if (has_term) begin
				if (hit < 0 && free_slot >= 0) begin
					slot_used[free_slot] = 1'b1;
					slot_term[free_slot] = r.terminal_id;
					hit = free_slot;
				end
				if (hit >= 0) begin
					cur_valid = 1'b1;
					cur_slot = SLOT_W'(hit);
					res.ok = 1'b1;
					res.session_id = 3'(hit + 1);
				end
			end
			CMD_DETACH: if (has_term && hit >= 0) begin
				slot_used[hit] = 1'b0;
				if (cur_valid && cur_slot == SLOT_W'(hit))
					cur_valid = 1'b0;
			end
			CMD_DETACH_CUR: if (cur_valid) begin
				slot_used[cur_slot] = 1'b0;
				cur_valid = 1'b0;
			end
			CMD_FIND: if (has_term && hit >= 0) begin
				res.ok = 1'b1;
				res.session_id = 3'(hit + 1);
			end
			default: ;
		endcase
		res.current_valid = cur_valid && slot_used[cur_slot];
		res.current_id = res.current_valid ? 3'(int'(cur_slot) + 1) : 3'd0;
		for (int i = 0; i < SLOTS; i++)
			if (slot_used[i])
				used_n++;
		res.active_count = 3'(used_n);
		return res;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s expected %0d got %0d", name, exp_v, act_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_used[i] = 1'b0;
				slot_term[i] = 16'd0;
			end
			cur_valid = 1'b0;
			cur_slot = '0;
			expected_q.delete();
			fails = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result beat with no request outstanding");
					fails++;
				end else begin
					want = expected_q.pop_front();
					check_field("ok", 16'(want.ok), 16'(result.ok));
					check_field("session_id", 16'(want.session_id),
						16'(result.session_id));
					check_field("current_valid", 16'(want.current_valid),
						16'(result.current_valid));
					check_field("current_id", 16'(want.current_id),
						16'(result.current_id));
					check_field("active_count", 16'(want.active_count),
						16'(result.active_count));
					checked++;
				end
			end
			if (start && !busy)
				expected_q.push_back(predict_step(request));
			pending = expected_q.size();
		end
	end

endmodule

FILE: tb/tb_session_slot_table.sv
`timescale 1ns / 1ps

module tb_session_slot_table;
	import sst_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	request_t    request;
	logic        busy;
	logic        done;
	result_t     result;
	int          fails;
	int          pending;
	int          checked;
	int          beats_by_cmd [4];
	int          idle_pct;
	bit          quiet;
	logic [15:0] term_pool [6];

	initial clk = 1'b0;
	always #2 clk = ~clk;

	session_slot_table DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	sst_result_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result),
		.fails   (fails),
		.pending (pending),
		.checked (checked)
	);

	initial begin
		#2_000_000;
		$display("tb_session_slot_table failed");
		$finish;
	end

	task automatic drain();
		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic send_beat(input cmd_e_t cmd, input logic [15:0] term);
		start = 1'b1;
		request.command = cmd;
		request.terminal_id = term;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		beats_by_cmd[int'(cmd)]++;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			request = request_t'($urandom);
			repeat ($urandom_range(1, 13))
				@(negedge clk);
		end
	endtask

	initial begin
		int          sel;
		logic [15:0] term;
		cmd_e_t      cmd;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		quiet = 1'b1;
		idle_pct = 0;
		foreach (beats_by_cmd[k])
			beats_by_cmd[k] = 0;
		repeat (3)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_beat(CMD_FIND, 16'h1234);
		send_beat(CMD_DETACH, 16'h1234);
		send_beat(CMD_DETACH_CUR, 16'h0000);
		send_beat(CMD_ATTACH, 16'h0000);
		send_beat(CMD_DETACH, 16'h0000);
		send_beat(CMD_FIND, 16'h0000);
		send_beat(CMD_ATTACH, 16'hFFFF);
		send_beat(CMD_ATTACH, 16'h0001);
		send_beat(CMD_ATTACH, 16'hFFFF);
		send_beat(CMD_ATTACH, 16'h8000);
		send_beat(CMD_ATTACH, 16'h7FFF);
		send_beat(CMD_ATTACH, 16'h5555);
		send_beat(CMD_FIND, 16'h7FFF);
		send_beat(CMD_FIND, 16'hAAAA);
		send_beat(CMD_DETACH, 16'h0001);
		send_beat(CMD_ATTACH, 16'hAAAA);
		send_beat(CMD_DETACH, 16'hAAAA);
		send_beat(CMD_DETACH_CUR, 16'hFFFF);
		send_beat(CMD_ATTACH, 16'h8000);
		send_beat(CMD_DETACH_CUR, 16'h0000);
		send_beat(CMD_DETACH, 16'hFFFF);
		send_beat(CMD_DETACH, 16'h7FFF);
		drain();

		quiet = 1'b0;
		for (int n = 0; n < 850; n++) begin
			if (n % 100 == 0)
				idle_pct = $urandom_range(0, 4) * 10;
			if (n % 128 == 0)
				foreach (term_pool[k])
					term_pool[k] = 16'($urandom_range(1, 65535));
			if (n >= 700)
				quiet = 1'b1;
			if (n % 200 == 199)
				drain();
			sel = $urandom_range(0, 19);
			if (sel < 8)
				cmd = CMD_ATTACH;
			else if (sel < 12)
				cmd = CMD_DETACH;
			else if (sel < 14)
				cmd = CMD_DETACH_CUR;
			else
				cmd = CMD_FIND;
			term = term_pool[$urandom_range(0, 5)];
			case ($urandom_range(0, 19))
				0:       term = 16'd0;
				1, 2:    term = 16'($urandom);
				default: ;
			endcase
			send_beat(cmd, term);
		end
		drain();
		repeat (20)
			@(negedge clk);

		$display("beats sent: %0d attach, %0d detach, %0d detach-current, %0d find",
			beats_by_cmd[0], beats_by_cmd[1], beats_by_cmd[2], beats_by_cmd[3]);
		$display("results compared: %0d, mismatches: %0d", checked, fails);
		if (fails == 0)
			$display("tb_session_slot_table passed");
		else
			$display("tb_session_slot_table failed");
		$finish;
	end

endmodule
